>>> sv/ttui_pkg.sv
// Shared types and constants for the text-to-unsigned-integer parser.
`timescale 1ns / 1ps

package ttui_pkg;

    // Longest text scan; the byte counter saturates just below it.
    localparam int unsigned MAX_SCAN_LEN = 4096;
    localparam logic [11:0] COUNT_LIMIT  =
        (MAX_SCAN_LEN - 1 > 4095) ? 12'd4095 : 12'(MAX_SCAN_LEN - 1);

    localparam logic [5:0] NO_DIGIT  = 6'h3F;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;
    localparam logic [5:0] BASE_MAX  = 6'd36;
    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_ONE  = 6'd1;
    localparam logic [5:0] BASE_RST  = 6'd10;

    localparam int unsigned IN_W  = 8;
    localparam int unsigned OUT_W = 80;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_SIGN   = 3'd1,
        PH_ZERO   = 3'd2,
        PH_PREFIX = 3'd3,
        PH_DIGITS = 3'd4
    } phase_t;

    // One classified text byte as it travels through the queue.
    typedef struct packed {
        logic [5:0] digit;   // digit value 0..35, NO_DIGIT otherwise
        logic       blank;
        logic       minus;
        logic       plus;
        logic       zero;
        logic       x_char;
    } cls_t;

endpackage

>>> sv/text_to_unsigned_integer_parser.sv
// Top level of the streaming text-to-unsigned-64-bit-integer parser.
// A terminating byte is queued at the edge that accepts it, then popped by the engine and
//   loaded into the result register, which raises m_tvalid.
// Throughput: 1 byte per cycle, multiply-add is combinational; a result held by m_tready
//   low stops the engine, and s_tready drops once QUEUE_DEPTH more bytes are queued.
// Reset (synchronous, aresetn low): flush queue and result, whitespace phase, base 10.
`timescale 1ns / 1ps

module text_to_unsigned_integer_parser
    import ttui_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4   // 2..32 entries
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [5:0]       cfg_wr_data,  // [5:0] number_base
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,      // [7:0] char_code
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata       // [63:0] parsed_value, [64] out_of_range,
                                           // [65] digits_found, [77:66] end_offset
);

    // Number base register; the engine samples it at the first non-blank byte.
    logic [5:0] number_base_reg, number_base_next;

    // Front end to queue request channel
    logic push_valid, push_ready;
    cls_t push_item;

    // Queue to parse engine request channel
    logic q_valid, q_pop;
    cls_t q_item;

    assign number_base_next = cfg_wr_en ? cfg_wr_data : number_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= BASE_RST;
        end else begin
            number_base_reg <= number_base_next;
        end
    end

    // Classify each incoming byte (digit value, blank, sign, zero, x).
    ttui_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Decouple the front end from the engine so each side can stall alone.
    ttui_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_item   (q_item)
    );

    // Advance the parse one byte per pop; a terminator loads the result register.
    ttui_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .number_base (number_base_reg),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // A parse without digits reports value 0, offset 0 and no overflow.
    a_no_digit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[65]) |->
            (m_tdata[63:0] == 64'd0 && m_tdata[77:66] == 12'd0 && !m_tdata[64]))
        else $error("result without digits carries a nonzero field");

    // Overflow saturates the magnitude and is never negated.
    a_overflow_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[64]) |-> (m_tdata[63:0] == '1 && m_tdata[65]))
        else $error("overflowed result is not all ones");

    // Backpressure on the input only ever comes from a queue holding requests.
    a_stall_has_backlog: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_valid)
        else $error("input stalled while the queue is empty");

endmodule

>>> sv/ttui_front.sv
// Front end: takes text bytes and classifies each one for the parse engine.
`timescale 1ns / 1ps

module ttui_front
    import ttui_pkg::*;
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,    // [7:0] char_code
    output logic              push_valid,
    input  logic              push_ready,
    output cls_t              push_item
);

    always_comb begin
        push_item        = '0;
        push_item.digit  = NO_DIGIT;
        if (s_tdata >= 8'h30 && s_tdata <= 8'h39) begin
            push_item.digit = 6'(s_tdata - 8'h30);
        end else if (s_tdata >= 8'h41 && s_tdata <= 8'h5A) begin
            push_item.digit = 6'(s_tdata - 8'h37);
        end else if (s_tdata >= 8'h61 && s_tdata <= 8'h7A) begin
            push_item.digit = 6'(s_tdata - 8'h57);
        end
        push_item.blank  = (s_tdata == 8'h20) || (s_tdata >= 8'h09 && s_tdata <= 8'h0D);
        push_item.minus  = (s_tdata == 8'h2D);
        push_item.plus   = (s_tdata == 8'h2B);
        push_item.zero   = (s_tdata == 8'h30);
        push_item.x_char = (s_tdata == 8'h78) || (s_tdata == 8'h58);
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

>>> sv/ttui_queue.sv
// Short FIFO of classified bytes between the front end and the parse engine.
`timescale 1ns / 1ps

module ttui_queue
    import ttui_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cls_t push_item,
    output logic pop_valid,
    input  logic pop_ready,
    output cls_t pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cls_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> sv/ttui_back.sv
// Parse engine: phase machine, multiply-add accumulator and result register.
`timescale 1ns / 1ps

module ttui_back
    import ttui_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [5:0]       number_base,
    input  logic             q_valid,
    output logic             q_pop,
    input  cls_t             q_item,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata
);

    phase_t      phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        ovf_reg, ovf_next;
    logic        any_reg, any_next;
    logic [5:0]  base_reg, base_next;
    logic [11:0] cnt_reg, cnt_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_tdata_reg;

    logic        emit;
    logic [11:0] emit_off;
    logic        go_first, go_digit, go_acc;
    logic [5:0]  first_base, digit_base, mul_base;
    logic [70:0] acc_sum;
    logic [63:0] emit_val;

    function automatic logic [11:0] sat_inc(input logic [11:0] c);
        return (c < COUNT_LIMIT) ? c + 12'd1 : c;
    endfunction

    assign q_pop = q_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        any_next   = any_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        emit_off   = '0;
        go_first   = 1'b0;
        go_digit   = 1'b0;
        go_acc     = 1'b0;
        first_base = base_reg;
        digit_base = base_reg;
        mul_base   = BASE_DEC;
        acc_sum    = '0;

        unique case (phase_reg)
            PH_SIGN: begin
                go_first = 1'b1;
            end
            PH_ZERO: begin
                if (q_item.x_char) begin
                    phase_next = PH_PREFIX;
                end else begin
                    digit_base = (base_reg == BASE_AUTO) ? BASE_OCT : base_reg;
                    base_next  = digit_base;
                    phase_next = PH_DIGITS;
                    go_digit   = 1'b1;
                end
            end
            PH_PREFIX: begin
                base_next  = BASE_HEX;
                digit_base = BASE_HEX;
                if (q_item.digit < BASE_HEX) begin
                    cnt_next   = sat_inc(sat_inc(cnt_reg));
                    go_acc     = 1'b1;
                    phase_next = PH_DIGITS;
                end else begin
                    emit     = 1'b1;
                    emit_off = cnt_reg;
                end
            end
            PH_DIGITS: begin
                go_digit = 1'b1;
            end
            default: begin
                // whitespace phase, also taken by unused phase codes
                if (q_item.blank) begin
                    cnt_next = sat_inc(cnt_reg);
                end else begin
                    first_base = number_base;
                    base_next  = number_base;
                    if (q_item.minus || q_item.plus) begin
                        neg_next   = q_item.minus;
                        cnt_next   = sat_inc(cnt_reg);
                        phase_next = PH_SIGN;
                    end else begin
                        go_first = 1'b1;
                    end
                end
            end
        endcase

        // first byte after whitespace and sign
        if (go_first) begin
            if (first_base == BASE_ONE || first_base > BASE_MAX) begin
                emit     = 1'b1;
                emit_off = '0;
            end else if (q_item.zero && (first_base == BASE_AUTO || first_base == BASE_HEX)) begin
                any_next   = 1'b1;
                acc_next   = '0;
                cnt_next   = sat_inc(cnt_reg);
                phase_next = PH_ZERO;
                base_next  = first_base;
            end else begin
                digit_base = (first_base == BASE_AUTO) ? BASE_DEC : first_base;
                base_next  = digit_base;
                phase_next = PH_DIGITS;
                go_digit   = 1'b1;
            end
        end

        if (go_digit) begin
            if (q_item.digit >= digit_base) begin
                emit     = 1'b1;
                emit_off = any_reg ? cnt_reg : 12'd0;
            end else begin
                go_acc   = 1'b1;
                cnt_next = sat_inc(cnt_reg);
            end
        end

        // one multiply-add per byte; a carry above bit 63 means overflow
        mul_base = (digit_base >= 6'd2) ? digit_base : BASE_DEC;
        acc_sum  = ({7'd0, acc_reg} * {65'd0, mul_base}) + {65'd0, q_item.digit};
        if (go_acc) begin
            any_next = 1'b1;
            if (!ovf_reg) begin
                if (acc_sum[70:64] != '0) begin
                    ovf_next = 1'b1;
                    acc_next = '1;
                end else begin
                    acc_next = acc_sum[63:0];
                end
            end
        end

        if (emit) begin
            phase_next = PH_SPACE;
            acc_next   = '0;
            neg_next   = 1'b0;
            ovf_next   = 1'b0;
            any_next   = 1'b0;
            base_next  = '0;
            cnt_next   = '0;
        end

        emit_val = (neg_reg && !ovf_reg) ? (64'd0 - acc_reg) : acc_reg;

        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (q_pop && emit) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SPACE;
            acc_reg      <= '0;
            neg_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
            any_reg      <= 1'b0;
            base_reg     <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (q_pop) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                ovf_reg   <= ovf_next;
                any_reg   <= any_next;
                base_reg  <= base_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            m_tdata_reg <= {2'b00, emit_off, any_reg, ovf_reg, emit_val};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> dv/text_to_unsigned_integer_parser_test.sv
// Self-checking stream test of the text-to-unsigned-integer parser against a local predictor.
`timescale 1ns / 1ps

module text_to_unsigned_integer_parser_test
    import ttui_pkg::*;
();

    // Character codes used by stimulus and predictor.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_NINE  = "9";
    localparam logic [7:0] CH_UA    = "A";
    localparam logic [7:0] CH_UZ    = "Z";
    localparam logic [7:0] CH_LA    = "a";
    localparam logic [7:0] CH_LZ    = "z";
    localparam logic [7:0] CH_UX    = "X";
    localparam logic [7:0] CH_LX    = "x";
    localparam logic [7:0] CH_HIGH  = 8'hFF;

    localparam logic [63:0] ALL_ONES = '1;

    // Leave margin after the output drains before touching the base register.
    localparam int SETTLE_CYCLES = 8;
    // Cycles without any accepted request before the run is declared hung.
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_SEGMENTS = 12;
    localparam int SEGMENT_CHARS   = 84;

    // Radix per random segment; covers auto detection, both radix extremes and bad radixes.
    localparam logic [5:0] RANDOM_BASES [RANDOM_SEGMENTS] = '{
        BASE_DEC, BASE_AUTO, BASE_HEX, 6'd2, BASE_MAX, BASE_OCT,
        BASE_ONE, 6'd37, 6'd63, BASE_AUTO, 6'd7, BASE_HEX
    };
    // Idling modes: none, sender idle, receiver stalling, both.
    localparam int SEND_IDLE  [4] = '{0, 82, 0, 22};
    localparam int RECV_STALL [4] = '{0, 0, 82, 22};

    typedef struct packed {
        logic [11:0] end_offset;
        logic        digits_found;
        logic        out_of_range;
        logic [63:0] parsed_value;
    } parse_result_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [5:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;      // [7:0] char_code
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [79:0] m_tdata;               // [63:0] parsed_value, [64] out_of_range,
                                        // [65] digits_found, [77:66] end_offset

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_chars     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    parse_result_t pending_results[$];

    // Predictor state: a shadow of the parser's phase, accumulator and flags.
    phase_t      cur_phase;
    logic [63:0] value_acc;
    logic        minus_seen;
    logic        saturated;
    logic        digit_seen;
    logic [5:0]  radix;
    logic [11:0] byte_count;
    logic [5:0]  base_setting;

    text_to_unsigned_integer_parser dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void restart_parse();
        cur_phase  = PH_SPACE;
        value_acc  = '0;
        minus_seen = 1'b0;
        saturated  = 1'b0;
        digit_seen = 1'b0;
        radix      = BASE_AUTO;
        byte_count = '0;
    endfunction

    function automatic void bump_count();
        if (byte_count < COUNT_LIMIT) begin
            byte_count = byte_count + 12'd1;
        end
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Map a byte to its digit value 0..35, or NO_DIGIT.
    function automatic logic [5:0] char_digit(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return 6'(c - CH_ZERO);
        if (c >= CH_UA && c <= CH_UZ)     return 6'(c - CH_UA + 8'd10);
        if (c >= CH_LA && c <= CH_LZ)     return 6'(c - CH_LA + 8'd10);
        return NO_DIGIT;
    endfunction

    // Multiply-add one digit; saturate to all ones once the value leaves 64 bits.
    function automatic void add_digit(input logic [5:0] d);
        logic [63:0] b;
        logic [63:0] cutoff;
        logic [63:0] cutlim;
        b          = (radix >= 6'd2) ? 64'(radix) : 64'(BASE_DEC);
        cutoff     = ALL_ONES / b;
        cutlim     = ALL_ONES % b;
        digit_seen = 1'b1;
        if (!saturated) begin
            if (value_acc > cutoff || (value_acc == cutoff && 64'(d) > cutlim)) begin
                saturated = 1'b1;
                value_acc = ALL_ONES;
            end else begin
                value_acc = value_acc * b + 64'(d);
            end
        end
    endfunction

    function automatic void close_parse(input logic [11:0] offset);
        parse_result_t r;
        r.parsed_value = (minus_seen && !saturated) ? -value_acc : value_acc;
        r.out_of_range = saturated;
        r.digits_found = digit_seen;
        r.end_offset   = offset;
        pending_results.push_back(r);
        restart_parse();
    endfunction

    function automatic void digit_step(input logic [7:0] c);
        logic [5:0] d;
        d = char_digit(c);
        if (d >= radix) begin
            close_parse(digit_seen ? byte_count : 12'd0);
        end else begin
            add_digit(d);
            bump_count();
        end
    endfunction

    // First byte after whitespace and sign: reject bad radixes, catch a leading zero.
    function automatic void first_step(input logic [7:0] c);
        if (radix == BASE_ONE || radix > BASE_MAX) begin
            close_parse(12'd0);
        end else if (c == CH_ZERO && (radix == BASE_AUTO || radix == BASE_HEX)) begin
            digit_seen = 1'b1;
            value_acc  = '0;
            bump_count();
            cur_phase  = PH_ZERO;
        end else begin
            if (radix == BASE_AUTO) begin
                radix = BASE_DEC;
            end
            cur_phase = PH_DIGITS;
            digit_step(c);
        end
    endfunction

    function automatic void predict_char(input logic [7:0] c);
        logic [5:0] d;
        case (cur_phase)
            PH_SIGN: begin
                first_step(c);
            end
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    cur_phase = PH_PREFIX;
                end else begin
                    if (radix == BASE_AUTO) begin
                        radix = BASE_OCT;
                    end
                    cur_phase = PH_DIGITS;
                    digit_step(c);
                end
            end
            PH_PREFIX: begin
                radix = BASE_HEX;
                d     = char_digit(c);
                if (d < BASE_HEX) begin
                    // count both the 'x' and this digit
                    bump_count();
                    bump_count();
                    add_digit(d);
                    cur_phase = PH_DIGITS;
                end else begin
                    // the leading zero is the number; offset points at the 'x'
                    close_parse(byte_count);
                end
            end
            PH_DIGITS: begin
                digit_step(c);
            end
            default: begin
                if (is_blank(c)) begin
                    bump_count();
                end else begin
                    // sample the base register at the first non-blank byte
                    radix = base_setting;
                    if (c == CH_MINUS || c == CH_PLUS) begin
                        minus_seen = (c == CH_MINUS);
                        bump_count();
                        cur_phase  = PH_SIGN;
                    end else begin
                        first_step(c);
                    end
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker and receiver stalls
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each accepted result with the oldest prediction, then pick the next
    // m_tready at random according to the current stall rate.
    always @(posedge aclk) begin
        parse_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("parsed_value", want.parsed_value, m_tdata[63:0]);
                check_field("out_of_range", 64'(want.out_of_range), 64'(m_tdata[64]));
                check_field("digits_found", 64'(want.digits_found), 64'(m_tdata[65]));
                check_field("end_offset", 64'(want.end_offset), 64'(m_tdata[77:66]));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Abort when no request moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one byte, with random idle cycles ahead of it; predict once it is taken.
    // Leave s_tvalid high afterwards so back-to-back requests need no gap.
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_char(c);
        sent_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    function automatic logic [7:0] random_blank();
        int k;
        k = $urandom_range(5);
        return (k == 0) ? CH_SPACE : 8'(CH_TAB + k - 1);
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return 8'(CH_ZERO + d);
        return 8'((($urandom_range(1) != 0) ? CH_LA : CH_UA) + d - 10);
    endfunction

    // Close any open parse, drop s_tvalid and drain every pending result.
    task automatic settle();
        if (cur_phase != PH_SPACE || byte_count != 0) begin
            send_char(CH_NUL);
        end
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the base register on an idle block and switch the idling mode.
    task automatic start_phase(input logic [5:0] base, input int send_pct, input int recv_pct);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= base;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        base_setting  = base;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // One well-formed number with random content, or now and then a noise byte.
    task automatic send_number();
        logic [63:0] v;
        logic [63:0] g;
        int          digs[$];
        int          n;
        int          pick;
        logic        bare_prefix;
        bare_prefix = 1'b0;
        if ($urandom_range(99) < 12) begin
            send_char(8'($urandom_range(255)));
            return;
        end
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
        repeat (n) send_char(random_blank());
        pick = $urandom_range(3);
        if (pick == 0) begin
            send_char(CH_MINUS);
        end else if (pick == 1) begin
            send_char(CH_PLUS);
        end
        g = (base_setting >= 6'd2 && base_setting <= BASE_MAX) ? 64'(base_setting)
                                                               : 64'(BASE_DEC);
        pick = $urandom_range(3);
        if ((base_setting == BASE_AUTO || base_setting == BASE_HEX) && pick == 0) begin
            send_char(CH_ZERO);
            send_char(($urandom_range(1) != 0) ? CH_LX : CH_UX);
            g           = 64'(BASE_HEX);
            bare_prefix = ($urandom_range(7) == 0);
        end else if (base_setting == BASE_AUTO && pick == 1) begin
            send_char(CH_ZERO);
            g = 64'(BASE_OCT);
        end
        if ($urandom_range(3) == 0) begin
            // spell out a value at or near the 64-bit limit or a random one, sometimes with one extra digit
            case ($urandom_range(3))
                0:       v = ALL_ONES;
                1:       v = ALL_ONES - 64'($urandom_range(40));
                2:       v = {$urandom, $urandom};
                default: v = {$urandom, $urandom} >> $urandom_range(63);
            endcase
            do begin
                digs.push_front(int'(v % g));
                v = v / g;
            end while (v != 0);
            if ($urandom_range(2) == 0) begin
                digs.push_back($urandom_range(int'(g) - 1));
            end
        end else begin
            n = ($urandom_range(9) == 0) ? $urandom_range(9, 70) : $urandom_range(1, 8);
            repeat (n) digs.push_back($urandom_range(int'(g) - 1));
        end
        if (bare_prefix) begin
            digs.delete();
        end
        foreach (digs[i]) begin
            send_char(digit_char(digs[i]));
        end
        case ($urandom_range(3))
            0:       send_char(CH_SPACE);
            1:       send_char(CH_NUL);
            2:       send_char(CH_HIGH);
            default: send_char(8'($urandom_range(255)));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset base 10: every blank kind, minus, a top-bit terminator, then a lone sign.
    task automatic test_blanks_and_signs();
        send_text("\t\n\v\f\015 -9");
        send_char(CH_HIGH);
        send_text("+x");
    endtask

    // Auto base: bare prefix, octal by leading zero, upper-case prefix with NUL end.
    task automatic test_automatic_base();
        start_phase(BASE_AUTO, 0, 0);
        send_text("0xg017 0X1f");
        send_char(CH_NUL);
    endtask

    // Bad radixes accept no digit at all.
    task automatic test_bad_radix();
        start_phase(BASE_ONE, 22, 22);
        send_text("5");
        start_phase(6'd63, 22, 22);
        send_text("-7");
    endtask

    // Overflow keeps consuming digits and is never negated.
    task automatic test_overflow();
        start_phase(BASE_MAX, 82, 82);
        send_text("-zzzzzzzzzzzzzzz!");
    endtask

    // A long run of leading blanks moves the offset of the terminator.
    task automatic test_long_text();
        start_phase(BASE_DEC, 0, 0);
        repeat (40) send_char(random_blank());
        send_text("5;");
    endtask

    // Random numbers across radix settings and all idling modes.
    task automatic test_random_text();
        int target;
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            start_phase(RANDOM_BASES[seg], SEND_IDLE[seg % 4], RECV_STALL[seg % 4]);
            target = sent_chars + SEGMENT_CHARS;
            while (sent_chars < target) send_number();
        end
    endtask

    initial begin
        base_setting = BASE_RST;
        restart_parse();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_blanks_and_signs();
        test_automatic_base();
        test_bad_radix();
        test_overflow();
        test_long_text();
        test_random_text();
        settle();

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
